@@ sv/stc_pkg.sv @@
`default_nettype none
package stc_pkg;
  typedef enum logic [1:0] {
    TYPE_BOOL = 2'd0,
    TYPE_INT  = 2'd1,
    TYPE_REAL = 2'd2,
    TYPE_CHAR = 2'd3
  } elem_type_t;

  localparam logic [1:0] REG_SOURCE = 2'd0;
  localparam logic [1:0] REG_TARGET = 2'd1;
  localparam int CfgIdxW = 8;
  localparam int CharRange = 256;
  localparam int CharW = $clog2(CharRange);

  typedef struct packed {
    logic       present;
    logic       last;
    elem_type_t src;
    elem_type_t tgt;
  } item_ctl_t;

  function automatic logic [5:0] lead_one(input logic [63:0] v);
    logic [5:0] p;
    p = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) p = 6'(i);
    end
    return p;
  endfunction
endpackage
`default_nettype wire

@@ sv/stc_front.sv @@
`default_nettype none
module stc_front
  import stc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        adv,
  input  wire logic        in_vld,
  input  wire logic [63:0] x,
  input  wire item_ctl_t   ctl,
  output logic             vld_r,
  output item_ctl_t        ctl_r,
  output logic [63:0]      x_r,
  output logic [63:0]      mag_r,
  output logic             neg_r
);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_r <= ctl;
      x_r   <= x;
      neg_r <= (ctl.src == TYPE_INT) && x[63];
      if (ctl.src == TYPE_INT) begin
        mag_r <= x[63] ? (64'd0 - x) : x;
      end else begin
        mag_r <= {56'd0, x[7:0]};
      end
    end
  end
endmodule
`default_nettype wire

@@ sv/stc_norm.sv @@
`default_nettype none
module stc_norm
  import stc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        adv,
  input  wire logic        vld,
  input  wire item_ctl_t   ctl,
  input  wire logic [63:0] x,
  input  wire logic [63:0] mag,
  input  wire logic        neg,
  output logic             vld_r,
  output item_ctl_t        ctl_r,
  output logic [63:0]      x_r,
  output logic [63:0]      norm_r,
  output logic [5:0]       p_r,
  output logic             zero_r,
  output logic             neg_r,
  output logic [63:0]      f2i_r
);
  logic [5:0]  p;
  logic [7:0]  ex;
  logic [63:0] fm;
  logic [63:0] fi;

  assign p = lead_one(mag);

  always_comb begin
    ex = x[30:23];
    fm = {40'd0, 1'b1, x[22:0]};
    if (ex == 8'hFF && x[22:0] != 23'd0) begin
      fi = 64'd0;
    end else if (ex < 8'd127) begin
      fi = 64'd0;
    end else if (ex >= 8'd190) begin
      fi = x[31] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end else begin
      if (ex >= 8'd150) begin
        fm = fm << (ex - 8'd150);
      end else begin
        fm = fm >> (8'd150 - ex);
      end
      fi = x[31] ? (64'd0 - fm) : fm;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_r  <= ctl;
      x_r    <= x;
      p_r    <= p;
      norm_r <= mag << (6'd63 - p);
      zero_r <= (mag == 64'd0);
      neg_r  <= neg;
      f2i_r  <= fi;
    end
  end
endmodule
`default_nettype wire

@@ sv/stc_round.sv @@
`default_nettype none
module stc_round
  import stc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        adv,
  input  wire logic        vld,
  input  wire item_ctl_t   ctl,
  input  wire logic [63:0] x,
  input  wire logic [63:0] norm,
  input  wire logic [5:0]  p,
  input  wire logic        zero,
  input  wire logic        neg,
  input  wire logic [63:0] f2i,
  output logic             vld_r,
  output logic             last_r,
  output logic [63:0]      res_r
);
  logic [24:0] keep;
  logic        half, sticky, up;
  logic [7:0]  fexp;
  logic [31:0] flt;
  logic [7:0]  byte_v;
  logic [63:0] res;

  always_comb begin
    half   = norm[39];
    sticky = |norm[38:0];
    up     = half && (sticky || norm[40]);
    keep   = {1'b0, norm[63:40]} + {24'd0, up};
    fexp   = 8'(p) + 8'd127;
    if (keep[24]) begin
      fexp = fexp + 8'd1;
      keep = keep >> 1;
    end
    flt = zero ? 32'd0 : {neg, fexp, keep[22:0]};
    byte_v = x[7:0];
    res = 64'd0;
    case (ctl.tgt)
      TYPE_BOOL: begin
        case (ctl.src)
          TYPE_BOOL: res = {56'd0, byte_v};
          TYPE_INT:  res = {63'd0, x != 64'd0};
          TYPE_REAL: res = {63'd0, x[30:0] != 31'd0};
          default:   res = {63'd0, byte_v != 8'd0};
        endcase
      end
      TYPE_INT: begin
        case (ctl.src)
          TYPE_BOOL: res = {63'd0, byte_v == 8'd1};
          TYPE_INT:  res = x;
          TYPE_REAL: res = f2i;
          default:   res = {56'd0, byte_v};
        endcase
      end
      TYPE_REAL: begin
        case (ctl.src)
          TYPE_BOOL: res = (byte_v == 8'd1) ? 64'h3F80_0000 : 64'd0;
          TYPE_REAL: res = {32'd0, x[31:0]};
          default:   res = {32'd0, flt};
        endcase
      end
      default: begin
        case (ctl.src)
          TYPE_BOOL: res = {63'd0, byte_v == 8'd1};
          TYPE_INT:  res = {56'd0, x[CharW-1:0]};
          TYPE_REAL: res = {56'd0, f2i[CharW-1:0]};
          default:   res = {56'd0, byte_v};
        endcase
      end
    endcase
    if (!ctl.present) res = 64'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r  <= res;
      last_r <= ctl.last;
    end
  end
endmodule
`default_nettype wire

@@ sv/scalar_type_converter.sv @@
`default_nettype none
// Streaming scalar type converter: each element is converted from the source
// type to the target type (0 bool, 1 int64, 2 float32, 3 char) set by the
// configuration registers. Three register stages (magnitude, normalize and
// float-to-int, round and select); one element per cycle while the output is
// taken. The whole pipeline stalls when the output is not taken. Write
// configuration only while the pipeline is empty.
module scalar_type_converter
  import stc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [63:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [63:0]        in_element_bits,
  input  wire logic               in_element_present,
  input  wire logic               in_last_element,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [63:0]             out_result_bits,
  output logic                    out_result_last
);
  elem_type_t src_r, tgt_r;
  logic       adv;
  item_ctl_t  ctl0;

  logic        v1_r, v2_r;
  item_ctl_t   c1_r, c2_r;
  logic [63:0] x1_r, x2_r, mag1_r, norm2_r, f2i2_r;
  logic        neg1_r, neg2_r, zero2_r;
  logic [5:0]  p2_r;

  assign cfg_ready = 1'b1;
  assign adv       = out_ready || !out_valid;
  assign in_ready  = adv;
  assign ctl0      = '{present: in_element_present, last: in_last_element,
                       src: src_r, tgt: tgt_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r <= TYPE_INT;
      tgt_r <= TYPE_INT;
    end else if (cfg_valid) begin
      if (cfg_index == CfgIdxW'(REG_SOURCE)) src_r <= elem_type_t'(cfg_data[1:0]);
      else if (cfg_index == CfgIdxW'(REG_TARGET)) tgt_r <= elem_type_t'(cfg_data[1:0]);
    end
  end

  stc_front u_front (
    .clk, .rst_n, .adv, .in_vld(in_valid), .x(in_element_bits), .ctl(ctl0),
    .vld_r(v1_r), .ctl_r(c1_r), .x_r(x1_r), .mag_r(mag1_r), .neg_r(neg1_r)
  );

  stc_norm u_norm (
    .clk, .rst_n, .adv, .vld(v1_r), .ctl(c1_r), .x(x1_r), .mag(mag1_r),
    .neg(neg1_r), .vld_r(v2_r), .ctl_r(c2_r), .x_r(x2_r), .norm_r(norm2_r),
    .p_r(p2_r), .zero_r(zero2_r), .neg_r(neg2_r), .f2i_r(f2i2_r)
  );

  stc_round u_round (
    .clk, .rst_n, .adv, .vld(v2_r), .ctl(c2_r), .x(x2_r), .norm(norm2_r),
    .p(p2_r), .zero(zero2_r), .neg(neg2_r), .f2i(f2i2_r),
    .vld_r(out_valid), .last_r(out_result_last), .res_r(out_result_bits)
  );
endmodule
`default_nettype wire

@@ tb/scalar_type_converter_tb.sv @@
`default_nettype none
module scalar_type_converter_tb;
  import stc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [63:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic [63:0] in_element_bits;
  logic in_element_present;
  logic in_last_element;
  logic out_valid;
  logic out_ready;
  logic [63:0] out_result_bits;
  logic out_result_last;

  scalar_type_converter dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_element_bits(in_element_bits),
    .in_element_present(in_element_present), .in_last_element(in_last_element),
    .out_valid(out_valid), .out_ready(out_ready), .out_result_bits(out_result_bits),
    .out_result_last(out_result_last)
  );

  typedef struct {
    logic [63:0] bits;
    logic        last;
  } conv_result_t;

  typedef struct {
    elem_type_t  src;
    elem_type_t  tgt;
    logic [63:0] bits;
    logic        present;
    logic        last;
    logic        known;
    logic [63:0] want;
  } vector_row_t;

  elem_type_t src_type;
  elem_type_t tgt_type;
  conv_result_t pending_results[$];
  int errors;
  int idle_cycles;
  int sent;
  int received;
  bit quiet;
  bit hold_off;
  int hold_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [63:0] float_to_int64(logic [31:0] f);
    logic [7:0] ex;
    logic [22:0] man;
    logic [63:0] mag;
    ex = f[30:23];
    man = f[22:0];
    if (ex == 8'hFF && man != 0) return 64'd0;
    if (ex < 8'd127) return 64'd0;
    if (ex >= 8'd190) return f[31] ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF;
    mag = {40'd0, 1'b1, man};
    if (ex >= 8'd150) mag = mag << (ex - 8'd150);
    else mag = mag >> (8'd150 - ex);
    return f[31] ? -mag : mag;
  endfunction

  function automatic logic [63:0] int64_to_float(logic [63:0] v);
    logic [63:0] mag;
    logic [63:0] keep;
    logic [63:0] rem;
    logic [63:0] half;
    int p;
    int sh;
    mag = v[63] ? -v : v;
    if (mag == 0) return 64'd0;
    p = 63;
    while (!mag[p]) p--;
    if (p <= 23) begin
      keep = mag << (23 - p);
    end else begin
      sh = p - 23;
      rem = mag & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      keep = mag >> sh;
      if (rem > half || (rem == half && keep[0])) begin
        keep++;
        if (keep == (64'd1 << 24)) begin
          keep = keep >> 1;
          p++;
        end
      end
    end
    return {32'd0, v[63], 8'(p + 127), keep[22:0]};
  endfunction

  function automatic logic [63:0] convert_element(elem_type_t s, elem_type_t t, logic [63:0] x,
                                                  logic present);
    logic [7:0] b;
    logic [31:0] f;
    logic [63:0] fi;
    b = x[7:0];
    f = x[31:0];
    fi = float_to_int64(f);
    if (!present) return 64'd0;
    case (t)
      TYPE_BOOL: begin
        case (s)
          TYPE_BOOL: return {56'd0, b};
          TYPE_INT: return {63'd0, x != 0};
          TYPE_REAL: return {63'd0, f[30:0] != 0};
          default: return {63'd0, b != 0};
        endcase
      end
      TYPE_INT: begin
        case (s)
          TYPE_BOOL: return {63'd0, b == 8'd1};
          TYPE_INT: return x;
          TYPE_REAL: return fi;
          default: return {56'd0, b};
        endcase
      end
      TYPE_REAL: begin
        case (s)
          TYPE_BOOL: return (b == 8'd1) ? 64'h3F800000 : 64'd0;
          TYPE_INT: return int64_to_float(x);
          TYPE_REAL: return {32'd0, f};
          default: return int64_to_float({56'd0, b});
        endcase
      end
      default: begin
        case (s)
          TYPE_BOOL: return {63'd0, b == 8'd1};
          TYPE_INT: return {56'd0, x[7:0]};
          TYPE_REAL: return {56'd0, fi[7:0]};
          default: return {56'd0, b};
        endcase
      end
    endcase
  endfunction

  task automatic write_type_reg(logic [CfgIdxW-1:0] idx, logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CfgIdxW'(REG_SOURCE)) src_type = elem_type_t'(value[1:0]);
    else if (idx == CfgIdxW'(REG_TARGET)) tgt_type = elem_type_t'(value[1:0]);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    cfg_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_types(elem_type_t s, elem_type_t t);
    drain_results();
    write_type_reg(CfgIdxW'(REG_SOURCE), {$urandom, $urandom} & ~64'h3 | 64'(s));
    write_type_reg(CfgIdxW'(REG_TARGET), 64'(t));
  endtask

  task automatic send_element(logic [63:0] bits, logic present, logic last);
    cfg_valid <= 1'b0;
    while (!quiet && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_element_bits <= bits;
    in_element_present <= present;
    in_last_element <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back('{convert_element(src_type, tgt_type, bits, present), last});
    sent++;
  endtask

  function automatic logic [63:0] random_bits(elem_type_t s);
    logic [63:0] r;
    int pick;
    r = {$urandom, $urandom};
    pick = $urandom_range(9);
    case (s)
      TYPE_BOOL, TYPE_CHAR: begin
        if (pick < 4) r[7:0] = 8'($urandom_range(2));
      end
      TYPE_INT: begin
        if (pick < 3) r = 64'($signed(32'($urandom_range(600)) - 300));
        else if (pick < 5) r = r >> $urandom_range(63);
      end
      default: begin
        if (pick < 6) r[30:23] = 8'($urandom_range(110, 200));
        else if (pick == 6) r[30:23] = 8'hFF;
        else if (pick == 7) r[30:0] = 31'd0;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles + 1;
      if (hold_cycles >= 40) hold_off <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(99) >= 29);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      received++;
      if (pending_results.size() == 0) begin
        $error("unexpected transfer: result_bits %h", out_result_bits);
        errors++;
      end else begin
        if (out_result_bits !== pending_results[0].bits) begin
          $error("result_bits expected %h actual %h", pending_results[0].bits, out_result_bits);
          errors++;
        end
        if (out_result_last !== pending_results[0].last) begin
          $error("result_last expected %b actual %b", pending_results[0].last, out_result_last);
          errors++;
        end
        void'(pending_results.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("scalar_type_converter_tb: errors");
      $finish;
    end
  end

  vector_row_t vectors[] = '{
    '{TYPE_INT, TYPE_INT, 64'h8000000000000000, 1'b1, 1'b0, 1'b1, 64'h8000000000000000},
    '{TYPE_INT, TYPE_INT, 64'hFFFFFFFFFFFFFFFF, 1'b0, 1'b1, 1'b1, 64'd0},
    '{TYPE_REAL, TYPE_INT, 64'h7FC00000, 1'b1, 1'b0, 1'b1, 64'd0},
    '{TYPE_REAL, TYPE_INT, 64'h7F800000, 1'b1, 1'b0, 1'b1, 64'h7FFFFFFFFFFFFFFF},
    '{TYPE_REAL, TYPE_INT, 64'hFF800000, 1'b1, 1'b0, 1'b1, 64'h8000000000000000},
    '{TYPE_REAL, TYPE_INT, 64'hC0700000, 1'b1, 1'b1, 1'b0, 64'd0},
    '{TYPE_REAL, TYPE_CHAR, 64'h43FA0000, 1'b1, 1'b0, 1'b0, 64'd0},
    '{TYPE_REAL, TYPE_CHAR, 64'hFFFFFFFF7FC00001, 1'b1, 1'b0, 1'b1, 64'd0},
    '{TYPE_REAL, TYPE_BOOL, 64'h80000000, 1'b1, 1'b0, 1'b1, 64'd0},
    '{TYPE_REAL, TYPE_BOOL, 64'h7FC00000, 1'b1, 1'b0, 1'b1, 64'd1},
    '{TYPE_REAL, TYPE_REAL, 64'hFFFFFFFF7FC12345, 1'b1, 1'b1, 1'b1, 64'h7FC12345},
    '{TYPE_INT, TYPE_REAL, 64'h8000000000000000, 1'b1, 1'b0, 1'b1, 64'hDF000000},
    '{TYPE_INT, TYPE_REAL, 64'h0000000001000001, 1'b1, 1'b0, 1'b0, 64'd0},
    '{TYPE_INT, TYPE_REAL, 64'h0000000001000003, 1'b1, 1'b0, 1'b0, 64'd0},
    '{TYPE_INT, TYPE_REAL, 64'h7FFFFFFFFFFFFFFF, 1'b1, 1'b1, 1'b1, 64'h5F000000},
    '{TYPE_INT, TYPE_CHAR, 64'hFFFFFFFFFFFFFF80, 1'b1, 1'b0, 1'b1, 64'h80},
    '{TYPE_INT, TYPE_BOOL, 64'h0000000100000000, 1'b1, 1'b0, 1'b1, 64'd1},
    '{TYPE_BOOL, TYPE_BOOL, 64'hFF, 1'b1, 1'b0, 1'b1, 64'hFF},
    '{TYPE_BOOL, TYPE_INT, 64'hFFFFFFFFFFFFFF01, 1'b1, 1'b0, 1'b1, 64'd1},
    '{TYPE_BOOL, TYPE_REAL, 64'h2, 1'b1, 1'b0, 1'b1, 64'd0},
    '{TYPE_BOOL, TYPE_CHAR, 64'h1, 1'b1, 1'b1, 1'b1, 64'd1},
    '{TYPE_CHAR, TYPE_REAL, 64'hFF, 1'b1, 1'b0, 1'b1, 64'h437F0000},
    '{TYPE_CHAR, TYPE_INT, 64'hAAAAAAAAAAAAAAFF, 1'b1, 1'b0, 1'b1, 64'hFF},
    '{TYPE_CHAR, TYPE_BOOL, 64'h100, 1'b1, 1'b0, 1'b1, 64'd0},
    '{TYPE_CHAR, TYPE_CHAR, 64'h5A5A5A5A5A5A5A80, 1'b1, 1'b1, 1'b1, 64'h80}
  };

  initial begin
    int pairs;
    elem_type_t s;
    elem_type_t t;
    errors = 0;
    sent = 0;
    received = 0;
    idle_cycles = 0;
    quiet = 1'b0;
    hold_off = 1'b0;
    hold_cycles = 0;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_element_bits = '0;
    in_element_present = 1'b0;
    in_last_element = 1'b0;
    src_type = TYPE_INT;
    tgt_type = TYPE_INT;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (vectors[i]) begin
      if (vectors[i].src != src_type || vectors[i].tgt != tgt_type)
        set_types(vectors[i].src, vectors[i].tgt);
      if (vectors[i].known) begin
        drain_results();
        send_element(vectors[i].bits, vectors[i].present, vectors[i].last);
        pending_results[pending_results.size() - 1].bits = vectors[i].want;
      end else begin
        send_element(vectors[i].bits, vectors[i].present, vectors[i].last);
      end
    end

    drain_results();
    write_type_reg(CfgIdxW'(2), 64'h3);
    write_type_reg(CfgIdxW'(255), 64'h0);
    send_element(64'hFFFFFFFFFFFFFFFF, 1'b1, 1'b1);

    pairs = 0;
    for (int n = 0; n < 500; n++) begin
      if (n % 30 == 0) begin
        s = elem_type_t'($urandom_range(3));
        t = elem_type_t'($urandom_range(3));
        set_types(s, t);
        pairs++;
      end
      quiet = (n >= 200 && n < 260);
      if (n == 300) begin
        hold_cycles = 0;
        hold_off = 1'b1;
      end
      send_element(random_bits(src_type), $urandom_range(9) != 0, $urandom_range(1));
      if (n == 400) drain_results();
    end
    quiet = 1'b0;

    drain_results();
    $display("covered %0d transfers in, %0d out, over %0d random type pairs plus all 16 directed",
             sent, received, pairs);
    if (errors == 0)
      $display("scalar_type_converter_tb: clean");
    else
      $display("scalar_type_converter_tb: errors");
    $finish;
  end
endmodule
`default_nettype wire
